@@ hdl/pur_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pur_pkg
// Shared types and constants for the picture-unit register port: access
// codes, register numbers, field widths and the write-command structs
// passed to the sprite RAM and the palette.
// ---------------------------------------------------------------------------
package pur_pkg;

    localparam int SPRITE_BYTES    = 256;
    localparam int PALETTE_ENTRIES = 32;
    localparam int SPR_AW          = $clog2(SPRITE_BYTES);
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int PAL_DW          = 6;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 6;
    localparam int OUT_TDATA_W = 56;

    // access and event codes
    typedef enum logic [2:0] {
        FUNC_REG_READ    = 3'd0,
        FUNC_REG_WRITE   = 3'd1,
        FUNC_VBLANK      = 3'd2,
        FUNC_SPRITE_FLAG = 3'd3,
        FUNC_BUF_FILL    = 3'd4,
        FUNC_FRAME_START = 3'd5
    } t_func;

    // register numbers
    localparam logic [2:0] REG_CTRL0   = 3'd0;
    localparam logic [2:0] REG_CTRL1   = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_SPR_PTR = 3'd3;
    localparam logic [2:0] REG_SPR_DAT = 3'd4;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDR    = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    localparam logic [7:0]  ATTR_MASK      = 8'hE3;
    localparam logic [7:0]  LATCH_LOW_MASK = 8'h1F;
    localparam logic [7:0]  MONO_MASK      = 8'hF0;
    localparam logic [5:0]  PAL_PAGE       = 6'h3F;
    localparam logic [14:0] STEP_ROW       = 15'd32;
    localparam logic [14:0] STEP_COL       = 15'd1;

    typedef struct packed {
        logic              we;
        logic [SPR_AW-1:0] addr;
        logic [7:0]        data;
    } t_spr_wr;

    typedef struct packed {
        logic              we;
        logic [PAL_AW-1:0] idx;
        logic [PAL_DW-1:0] data;
    } t_pal_wr;

endpackage
`default_nettype wire

@@ hdl/picture_unit_register_port.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// picture_unit_register_port
// CPU-side register port of a picture unit: control, status, sprite RAM,
// palette, scroll/address latches, open bus and buffered VRAM reads.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tdata, tuser
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata
//  cfg       in         i_cfg_valid / o_cfg_ready       i_cfg_data
//
// One transaction per cycle sustained while m_axis is not stalled; an accepted
// transaction passes through the input register, then the result register.
// The sprite RAM read is prefetched at the pointer every cycle, so a
// sprite-data read completes in the same single pass.
// Reset clears all control state at once; sprite RAM uses per-byte valid
// bits, so no clearing pass is needed. A stalled result holds while the
// next transaction waits in the input register.
// ---------------------------------------------------------------------------
module picture_unit_register_port (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // bus_data[7:0], flag_a[8], flag_b[9], in_visible_line[10], zero[15:11]
    input  wire logic [pur_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // func[2:0], reg_index[5:3]
    input  wire logic [pur_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // read_data[7:0], nmi_level[8], mem_addr[22:9], mem_read[23],
    // mem_write[24], mem_write_data[32:25], addr_strobe[33],
    // scroll_address[48:34], fine_x[51:49], zero[55:52]
    output logic      [pur_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [7:0]                         i_cfg_data
);

    typedef struct packed {
        logic [2:0]  fine_x;
        logic [14:0] scroll_address;
        logic        addr_strobe;
        logic [7:0]  mem_write_data;
        logic        mem_write;
        logic        mem_read;
        logic [13:0] mem_addr;
        logic        nmi_level;
        logic [7:0]  read_data;
    } t_result;

    // input register
    logic        r_in_valid;
    logic [2:0]  r_func;
    logic [2:0]  r_reg;
    logic [7:0]  r_data;
    logic        r_flag_a;
    logic        r_flag_b;
    logic        r_vis;

    // result register
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;

    // architectural state
    logic [7:0]  r_sec;
    logic [7:0]  r_ctrl0,  n_ctrl0;
    logic [7:0]  r_ctrl1,  n_ctrl1;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_ptr,    n_ptr;
    logic [7:0]  r_latch,  n_latch;
    logic [7:0]  r_buf,    n_buf;
    logic        r_toggle, n_toggle;
    logic [14:0] r_sl,     n_sl;
    logic [14:0] r_vaddr,  n_vaddr;
    logic [2:0]  r_fine_x, n_fine_x;
    logic        n_nmi;

    logic        fire;
    logic        in_accept;
    logic [2:0]  w_reg;
    logic [13:0] va;
    logic        va_pal;
    logic [14:0] vaddr_inc;
    logic [7:0]  status_rd;
    logic [7:0]  spr_byte;
    logic [7:0]  spr_q;
    logic [7:0]  pal_byte;
    logic [pur_pkg::PAL_DW-1:0] pal_q;

    pur_pkg::t_spr_wr spr_wr;
    pur_pkg::t_pal_wr pal_wr;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(pur_pkg::OUT_TDATA_W - $bits(t_result)){1'b0}}, r_out};

    // write swap on protection chips: registers 0 and 1 trade places
    assign w_reg = ((r_sec != 8'h00) && (r_reg[2:1] == 2'b00)) ?
                   {r_reg[2:1], ~r_reg[0]} : r_reg;

    assign va        = r_vaddr[13:0];
    assign va_pal    = (va[13:8] == pur_pkg::PAL_PAGE);
    assign vaddr_inc = r_vaddr + (r_ctrl0[2] ? pur_pkg::STEP_ROW : pur_pkg::STEP_COL);
    assign status_rd = (r_sec != 8'h00) ? ((r_status & 8'hC0) | r_sec) :
                       (r_status | (r_latch & pur_pkg::LATCH_LOW_MASK));
    assign pal_byte  = {2'b00, pal_q} & (r_ctrl1[0] ? pur_pkg::MONO_MASK : 8'hFF);

    always_comb begin
        if (r_vis && r_ctrl1[4]) begin
            spr_byte = 8'hFF;
        end else if (r_ptr[1:0] == 2'b10) begin
            spr_byte = r_data & pur_pkg::ATTR_MASK;
        end else begin
            spr_byte = r_data;
        end
    end

    always_comb begin
        n_ctrl0  = r_ctrl0;
        n_ctrl1  = r_ctrl1;
        n_status = r_status;
        n_ptr    = r_ptr;
        n_latch  = r_latch;
        n_buf    = r_buf;
        n_toggle = r_toggle;
        n_sl     = r_sl;
        n_vaddr  = r_vaddr;
        n_fine_x = r_fine_x;
        n_out    = '0;
        spr_wr   = '0;
        pal_wr   = '0;

        if (fire) begin
            unique case (r_func)
                pur_pkg::FUNC_REG_READ: begin
                    n_out.read_data = r_latch;
                    unique case (r_reg)
                        pur_pkg::REG_STATUS: begin
                            n_latch         = status_rd;
                            n_toggle        = 1'b0;
                            n_out.read_data = status_rd;
                            if (status_rd[7]) begin
                                n_status[7] = 1'b0;
                            end
                        end
                        pur_pkg::REG_SPR_DAT: begin
                            n_latch         = spr_q;
                            n_out.read_data = spr_q;
                        end
                        pur_pkg::REG_DATA: begin
                            n_vaddr = vaddr_inc;
                            if (va_pal) begin
                                n_out.read_data = pal_byte;
                            end else begin
                                n_latch         = r_buf;
                                n_out.read_data = r_buf;
                                n_out.mem_read  = 1'b1;
                                n_out.mem_addr  = va;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                pur_pkg::FUNC_REG_WRITE: begin
                    n_latch = r_data;
                    unique case (w_reg)
                        pur_pkg::REG_CTRL0: begin
                            n_ctrl0       = r_data;
                            n_sl[11:10]   = r_data[1:0];
                        end
                        pur_pkg::REG_CTRL1: begin
                            n_ctrl1 = r_data;
                        end
                        pur_pkg::REG_SPR_PTR: begin
                            n_ptr = r_data;
                        end
                        pur_pkg::REG_SPR_DAT: begin
                            spr_wr.we   = 1'b1;
                            spr_wr.addr = r_ptr[pur_pkg::SPR_AW-1:0];
                            spr_wr.data = spr_byte;
                            n_ptr       = r_ptr + 8'd1;
                            n_latch     = spr_byte;
                        end
                        pur_pkg::REG_SCROLL: begin
                            n_toggle = ~r_toggle;
                            if (!r_toggle) begin
                                n_sl[4:0] = r_data[7:3];
                                n_fine_x  = r_data[2:0];
                            end else begin
                                n_sl[9:5]   = r_data[7:3];
                                n_sl[14:12] = r_data[2:0];
                            end
                        end
                        pur_pkg::REG_ADDR: begin
                            n_toggle = ~r_toggle;
                            if (!r_toggle) begin
                                n_sl[14]   = 1'b0;
                                n_sl[13:8] = r_data[5:0];
                            end else begin
                                n_sl[7:0]         = r_data;
                                n_vaddr           = {r_sl[14:8], r_data};
                                n_out.addr_strobe = 1'b1;
                                n_out.mem_addr    = {r_sl[13:8], r_data};
                            end
                        end
                        pur_pkg::REG_DATA: begin
                            n_vaddr = vaddr_inc;
                            if (va_pal) begin
                                pal_wr.we   = 1'b1;
                                pal_wr.idx  = va[pur_pkg::PAL_AW-1:0];
                                pal_wr.data = r_data[pur_pkg::PAL_DW-1:0];
                            end else begin
                                n_out.mem_write      = 1'b1;
                                n_out.mem_addr       = va;
                                n_out.mem_write_data = r_data;
                            end
                        end
                        default: begin
                            // status write: only the open bus takes the byte
                        end
                    endcase
                end
                pur_pkg::FUNC_VBLANK: begin
                    if (r_flag_a) begin
                        n_status[7] = 1'b1;
                    end else begin
                        n_status[7:6] = 2'b00;
                    end
                end
                pur_pkg::FUNC_SPRITE_FLAG: begin
                    if (r_flag_a) begin
                        n_status[6] = 1'b1;
                    end
                    n_status[5] = r_flag_b;
                end
                pur_pkg::FUNC_BUF_FILL: begin
                    n_buf = r_data;
                end
                pur_pkg::FUNC_FRAME_START: begin
                    if (r_ctrl1[4:3] != 2'b00) begin
                        n_vaddr = r_sl;
                    end
                end
                default: begin
                end
            endcase
        end

        n_nmi                = n_ctrl0[7] & n_status[7];
        n_out.nmi_level      = n_nmi;
        n_out.scroll_address = n_vaddr;
        n_out.fine_x         = n_fine_x;
    end

    pur_spr_ram u_spr_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (spr_wr),
        .i_rd_addr (n_ptr[pur_pkg::SPR_AW-1:0]),
        .o_rd_data (spr_q)
    );

    pur_palette u_palette (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (pal_wr),
        .i_rd_idx  (va[pur_pkg::PAL_AW-1:0]),
        .o_rd_data (pal_q)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func   <= s_axis_tuser[2:0];
            r_reg    <= s_axis_tuser[5:3];
            r_data   <= s_axis_tdata[7:0];
            r_flag_a <= s_axis_tdata[8];
            r_flag_b <= s_axis_tdata[9];
            r_vis    <= s_axis_tdata[10];
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sec       <= '0;
            r_ctrl0     <= '0;
            r_ctrl1     <= '0;
            r_status    <= '0;
            r_ptr       <= '0;
            r_latch     <= '0;
            r_buf       <= '0;
            r_toggle    <= 1'b0;
            r_sl        <= '0;
            r_vaddr     <= '0;
            r_fine_x    <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_sec <= i_cfg_data;
            end
            r_ctrl0  <= n_ctrl0;
            r_ctrl1  <= n_ctrl1;
            r_status <= n_status;
            r_ptr    <= n_ptr;
            r_latch  <= n_latch;
            r_buf    <= n_buf;
            r_toggle <= n_toggle;
            r_sl     <= n_sl;
            r_vaddr  <= n_vaddr;
            r_fine_x <= n_fine_x;
        end
    end

endmodule
`default_nettype wire

@@ hdl/pur_spr_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pur_spr_ram
// 256-byte sprite RAM with one write port and one registered read port.
// Per-entry valid bits make never-written bytes read as zero after reset.
// ---------------------------------------------------------------------------
module pur_spr_ram (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire pur_pkg::t_spr_wr             i_wr,
    input  wire logic [pur_pkg::SPR_AW-1:0]   i_rd_addr,
    output logic      [7:0]                   o_rd_data
);

    logic [7:0]                  r_mem [pur_pkg::SPRITE_BYTES];
    logic [pur_pkg::SPRITE_BYTES-1:0] r_valid;
    logic [7:0]                  r_q;
    logic                        r_q_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_q_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_q_valid ? r_q : 8'h00;

endmodule
`default_nettype wire

@@ hdl/pur_palette.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pur_palette
// 32-entry palette held in flops. Writes to the two backdrop entries set
// all eight backdrop copies; writes to the other backdrop slots are dropped.
// ---------------------------------------------------------------------------
module pur_palette (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire pur_pkg::t_pal_wr             i_wr,
    input  wire logic [pur_pkg::PAL_AW-1:0]   i_rd_idx,
    output logic      [pur_pkg::PAL_DW-1:0]   o_rd_data
);

    logic [pur_pkg::PAL_DW-1:0] r_pal [pur_pkg::PALETTE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pur_pkg::PALETTE_ENTRIES; i++) begin
                r_pal[i] <= ((i % 4) != 0) ? pur_pkg::PAL_DW'(i) : '0;
            end
        end else if (i_wr.we) begin
            if (i_wr.idx[1:0] != 2'b00) begin
                r_pal[i_wr.idx] <= i_wr.data;
            end else if (i_wr.idx[3:0] == 4'h0) begin
                // mirror into every backdrop slot
                for (int i = 0; i < pur_pkg::PALETTE_ENTRIES; i += 4) begin
                    r_pal[i] <= i_wr.data;
                end
            end
        end
    end

    assign o_rd_data = r_pal[i_rd_idx];

endmodule
`default_nettype wire
